### design/mandel_pkg.sv
package mandel_pkg;

    localparam int COORD_WIDTH_DEF  = 64;
    localparam int PALETTE_SIZE_DEF = 90;
    localparam int TABLE_LEN        = 90;
    localparam int CNT_WIDTH        = 16;
    localparam int BAIL_WIDTH       = 3;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int CFG_ADDR_WIDTH   = 1;
    localparam int MUL_HALF         = 32;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BAIL_EXPONENT  = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MAX_ITERATIONS = 1'b1;

    localparam logic [BAIL_WIDTH-1:0] BAIL_RESET = 3'd2;
    localparam logic [CNT_WIDTH-1:0]  MAXIT_RESET = 16'd1024;

    typedef struct packed {
        logic signed [COORD_WIDTH_DEF-1:0] c_real;
        logic signed [COORD_WIDTH_DEF-1:0] c_imag;
    } t_in_item;

    typedef struct packed {
        logic [15:0] iteration_count;
        logic        escaped;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD,
        ST_DONE
    } t_state;

    // Hue wheel: six ramps of fifteen steps.
    function automatic logic [23:0] palette(input logic [6:0] idx);
        logic [7:0] up;
        logic [7:0] dn;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [3:0] s;
        logic [2:0] seg;
        logic [6:0] base;
        if (idx >= 7'd75) begin
            seg = 3'd5; base = 7'd75;
        end else if (idx >= 7'd60) begin
            seg = 3'd4; base = 7'd60;
        end else if (idx >= 7'd45) begin
            seg = 3'd3; base = 7'd45;
        end else if (idx >= 7'd30) begin
            seg = 3'd2; base = 7'd30;
        end else if (idx >= 7'd15) begin
            seg = 3'd1; base = 7'd15;
        end else begin
            seg = 3'd0; base = 7'd0;
        end
        s   = 4'(idx - base);
        up  = {s, s};
        dn  = 8'hff - up;
        r = 8'h00; g = 8'h00; b = 8'h00;
        case (seg)
            3'd0: begin r = 8'hff; g = up; end
            3'd1: begin r = (s == 4'd0) ? 8'hff : dn; g = 8'hff; end
            3'd2: begin g = 8'hff; b = up; end
            3'd3: begin g = (s == 4'd0) ? 8'hff : dn; b = 8'hff; end
            3'd4: begin b = 8'hff; r = up; end
            3'd5: begin r = 8'hff; b = (s == 4'd0) ? 8'hff : dn; end
            default: begin r = 8'h00; end
        endcase
        return {r, g, b};
    endfunction

endpackage

### design/mandelbrot_escape_time_pixel.sv
// Each pass runs ST_MUL (the multiplier rows), ST_SUM (the escape test) and
// ST_UPD (the update of z); an escaping point leaves from ST_SUM, a point at
// the limit from ST_MUL, and both go through ST_DONE to load the result.
// Throughput: one point at a time; the input stalls until the result is loaded.
// Reset (synchronous, active low) clears control state and sets the
// registers to bail 2, limit 1024.
module mandelbrot_escape_time_pixel #(
    parameter int PALETTE_SIZE = mandel_pkg::PALETTE_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  mandel_pkg::t_in_item   i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output mandel_pkg::t_out_item  o_data,
    input  logic                   i_cfg_we,
    input  logic [mandel_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [mandel_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);
    localparam int COORD_WIDTH = mandel_pkg::COORD_WIDTH_DEF;
    localparam int W  = COORD_WIDTH;
    localparam int F  = W - 4;
    localparam int ND = (W + mandel_pkg::MUL_HALF - 1) / mandel_pkg::MUL_HALF;
    localparam int LAT = ND * ND + 1;
    localparam int CW  = $clog2(LAT + 1);
    localparam int PW  = $clog2(PALETTE_SIZE + 1);

    mandel_pkg::t_state r_state, n_state;
    logic [2:0]  r_bail;
    logic [15:0] r_maxit;
    logic [15:0] r_count;
    logic [PW-1:0] r_pidx;
    logic [CW-1:0] r_wait;
    logic signed [W-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [2*W+1:0] r_diff, r_prod;
    logic [2*W:0]   r_sum;
    logic r_esc;
    logic r_ovalid;
    mandel_pkg::t_out_item r_out;

    logic [W-1:0] mag_r, mag_i;
    logic [2*W-1:0] p_rr, p_ii, p_ri;
    assign mag_r = r_zr[W-1] ? W'(-r_zr) : r_zr;
    assign mag_i = r_zi[W-1] ? W'(-r_zi) : r_zi;

    mandel_mul_row #(.W(W)) u_rr (.i_clk(i_clk), .i_a(mag_r), .i_b(mag_r), .o_p(p_rr));
    mandel_mul_row #(.W(W)) u_ii (.i_clk(i_clk), .i_a(mag_i), .i_b(mag_i), .o_p(p_ii));
    mandel_mul_row #(.W(W)) u_ri (.i_clk(i_clk), .i_a(mag_r), .i_b(mag_i), .o_p(p_ri));

    logic [2*W:0] limit;
    assign limit = (2*W+1)'(1) << (2 * F + 32'(r_bail));

    // Update: shifts, add of c and saturation.
    logic signed [2*W+1:0] d_full, p_full, zr_full, zi_full;
    logic signed [W-1:0] zr_sat, zi_sat;
    assign d_full = r_diff >>> F;
    assign p_full = r_prod >>> (F - 1);
    assign zr_full = d_full + (2*W+2)'(r_cr);
    assign zi_full = p_full + (2*W+2)'(r_ci);

    function automatic logic [W-1:0] sat(input logic signed [2*W+1:0] v);
        logic signed [2*W+1:0] mx;
        logic signed [2*W+1:0] mn;
        mx = (2*W+2)'({1'b0, {(W-1){1'b1}}});
        mn = -mx - 1;
        if (v > mx) return mx[W-1:0];
        if (v < mn) return mn[W-1:0];
        return v[W-1:0];
    endfunction
    assign zr_sat = sat(zr_full);
    assign zi_sat = sat(zi_full);

    logic acc_in, acc_out;
    assign acc_in  = i_valid && !o_stall;
    assign acc_out = r_ovalid && !i_stall;
    assign o_stall = (r_state != mandel_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mandel_pkg::ST_IDLE: if (acc_in) n_state = mandel_pkg::ST_MUL;
            mandel_pkg::ST_MUL: begin
                if (r_count >= r_maxit) n_state = mandel_pkg::ST_DONE;
                else if (r_wait == CW'(LAT)) n_state = mandel_pkg::ST_SUM;
            end
            mandel_pkg::ST_SUM: n_state = (r_sum > limit) ? mandel_pkg::ST_DONE
                                                          : mandel_pkg::ST_UPD;
            mandel_pkg::ST_UPD: n_state = mandel_pkg::ST_MUL;
            mandel_pkg::ST_DONE: if (!r_ovalid || acc_out) n_state = mandel_pkg::ST_IDLE;
            default: n_state = mandel_pkg::ST_IDLE;
        endcase
    end

    // The palette index wraps at the palette size and then again at the table length.
    logic [8:0] pidx_w;
    logic [8:0] pidx_m;
    assign pidx_w = 9'(r_pidx);
    always_comb begin
        pidx_m = pidx_w;
        if (pidx_m >= 9'(2 * mandel_pkg::TABLE_LEN))
            pidx_m = pidx_m - 9'(2 * mandel_pkg::TABLE_LEN);
        if (pidx_m >= 9'(mandel_pkg::TABLE_LEN))
            pidx_m = pidx_m - 9'(mandel_pkg::TABLE_LEN);
    end

    logic [23:0] rgb;
    assign rgb = mandel_pkg::palette(pidx_m[6:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mandel_pkg::ST_IDLE;
            r_bail   <= mandel_pkg::BAIL_RESET;
            r_maxit  <= mandel_pkg::MAXIT_RESET;
            r_ovalid <= 1'b0;
            r_wait   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    mandel_pkg::REG_BAIL_EXPONENT:  r_bail  <= i_cfg_data[2:0];
                    mandel_pkg::REG_MAX_ITERATIONS: r_maxit <= i_cfg_data;
                    default: ;
                endcase
            end
            r_wait <= (r_state == mandel_pkg::ST_MUL) ? CW'(r_wait + 1'b1) : '0;
            if (r_state == mandel_pkg::ST_DONE && (!r_ovalid || acc_out))
                r_ovalid <= 1'b1;
            else if (acc_out)
                r_ovalid <= 1'b0;
        end
        unique case (r_state)
            mandel_pkg::ST_IDLE: begin
                r_cr <= i_data.c_real; r_ci <= i_data.c_imag;
                r_zr <= i_data.c_real; r_zi <= i_data.c_imag;
                r_count <= '0; r_pidx <= '0; r_esc <= 1'b0;
            end
            mandel_pkg::ST_MUL: begin
                r_diff <= $signed({2'b00, p_rr}) - $signed({2'b00, p_ii});
                r_prod <= (r_zr[W-1] ^ r_zi[W-1]) ? -$signed({2'b00, p_ri})
                                                  : $signed({2'b00, p_ri});
                r_sum  <= {1'b0, p_rr} + {1'b0, p_ii};
            end
            mandel_pkg::ST_SUM: if (r_sum > limit) r_esc <= 1'b1;
            mandel_pkg::ST_UPD: begin
                r_zr <= zr_sat;
                r_zi <= zi_sat;
                r_count <= r_count + 16'd1;
                r_pidx <= (r_pidx == PW'(PALETTE_SIZE - 1)) ? '0 : PW'(r_pidx + 1'b1);
            end
            mandel_pkg::ST_DONE: begin
                if (!r_ovalid || acc_out) begin
                    r_out.iteration_count <= r_count;
                    r_out.escaped <= r_esc;
                    r_out.red   <= r_esc ? rgb[23:16] : 8'h00;
                    r_out.green <= r_esc ? rgb[15:8]  : 8'h00;
                    r_out.blue  <= r_esc ? rgb[7:0]   : 8'h00;
                end
            end
            default: ;
        endcase
    end
endmodule

### design/mandel_mul_cell.sv
// One cell of the multiplier row: adds one 32x32 partial product to a
// running sum and passes its operands on to the next cell.
module mandel_mul_cell #(
    parameter int W = 64
) (
    input  logic             i_clk,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  logic [2*W-1:0]   i_acc,
    input  logic [$clog2(W/mandel_pkg::MUL_HALF+1)-1:0] i_ai,
    input  logic [$clog2(W/mandel_pkg::MUL_HALF+1)-1:0] i_bi,
    output logic [W-1:0]     o_a,
    output logic [W-1:0]     o_b,
    output logic [2*W-1:0]   o_acc
);
    localparam int H = mandel_pkg::MUL_HALF;
    logic [H-1:0]     a_d;
    logic [H-1:0]     b_d;
    logic [2*H-1:0]   prod;
    logic [2*W-1:0]   sh;
    assign a_d  = H'(i_a >> (i_ai * H));
    assign b_d  = H'(i_b >> (i_bi * H));
    assign prod = a_d * b_d;
    assign sh   = (2*W)'(prod) << ((i_ai + i_bi) * H);
    always_ff @(posedge i_clk) begin
        o_a   <= i_a;
        o_b   <= i_b;
        o_acc <= i_acc + sh;
    end
endmodule

### design/mandel_mul_row.sv
// Unsigned multiplier as a row of cells, one partial product per cell.
module mandel_mul_row #(
    parameter int W = 64
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);
    localparam int H  = mandel_pkg::MUL_HALF;
    localparam int ND = (W + H - 1) / H;
    localparam int NC = ND * ND;
    localparam int IW = $clog2(W / H + 1);
    localparam int WP = ND * H;

    logic [WP-1:0]   a_c [NC+1];
    logic [WP-1:0]   b_c [NC+1];
    logic [2*WP-1:0] acc [NC+1];
    assign a_c[0] = WP'(i_a);
    assign b_c[0] = WP'(i_b);
    assign acc[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        mandel_mul_cell #(.W(WP)) u_cell (
            .i_clk (i_clk),
            .i_a   (a_c[k]),
            .i_b   (b_c[k]),
            .i_acc (acc[k]),
            .i_ai  (IW'(k / ND)),
            .i_bi  (IW'(k % ND)),
            .o_a   (a_c[k+1]),
            .o_b   (b_c[k+1]),
            .o_acc (acc[k+1])
        );
    end
    assign o_p = acc[NC][2*W-1:0];
endmodule

### design/mandel_checker.sv
module mandel_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input mandel_pkg::t_out_item o_data
);
    // A request is not taken while the previous point is still iterating.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("request taken twice");
    // A point that did not escape is black.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.escaped) |->
        (o_data.red == 8'h00 && o_data.green == 8'h00 && o_data.blue == 8'h00))
        else $error("bounded point not black");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("result dropped");
    a_no_result_at_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");
endmodule

bind mandelbrot_escape_time_pixel mandel_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    mandel_pkg::t_in_item i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    mandel_pkg::t_out_item o_data;
    logic i_cfg_we = 1'b0;
    logic [mandel_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr = '0;
    logic [mandel_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;

    mandel_pkg::t_in_item points[$];
    mandel_pkg::t_out_item pixels_due[$];
    logic [2:0] bail_cfg = mandel_pkg::BAIL_RESET;
    logic [15:0] maxit_cfg = mandel_pkg::MAXIT_RESET;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int unsigned gap_cnt = 0;
    int unsigned stall_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;

    mandelbrot_escape_time_pixel uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic signed [63:0] clamp64(input logic signed [127:0] w);
        if (w[127:63] == '0 || w[127:63] == '1)
            return w[63:0];
        return w[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    // Hue wheel of six ramps, fifteen steps each, 0x11 per step.
    function automatic logic [23:0] hue_color(input int unsigned idx);
        int unsigned seg;
        logic [7:0] up;
        logic [7:0] down;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        seg = idx / 15;
        up = 8'(17 * (idx % 15));
        down = (up == 8'h00) ? 8'hff : 8'hff - up;
        r = 8'h00;
        g = 8'h00;
        b = 8'h00;
        case (seg)
            0: begin r = 8'hff; g = up; end
            1: begin r = down; g = 8'hff; end
            2: begin g = 8'hff; b = up; end
            3: begin g = down; b = 8'hff; end
            4: begin r = up; b = 8'hff; end
            default: begin r = 8'hff; b = down; end
        endcase
        return {r, g, b};
    endfunction

    function automatic mandel_pkg::t_out_item escape_pixel(input mandel_pkg::t_in_item c,
                                                           input logic [2:0] bail,
                                                           input logic [15:0] limit);
        logic signed [63:0] zr;
        logic signed [63:0] zi;
        logic signed [127:0] er;
        logic signed [127:0] ei;
        logic signed [127:0] cr;
        logic signed [127:0] ci;
        logic signed [127:0] sr;
        logic signed [127:0] si;
        logic signed [127:0] d;
        logic signed [127:0] p;
        logic [127:0] mag;
        logic [127:0] thr;
        int unsigned n;
        bit esc;
        mandel_pkg::t_out_item res;
        zr = c.c_real;
        zi = c.c_imag;
        cr = c.c_real;
        ci = c.c_imag;
        thr = 128'd1 << (120 + bail);
        n = 0;
        esc = 1'b0;
        while (n < limit && !esc) begin
            er = zr;
            ei = zi;
            sr = er * er;
            si = ei * ei;
            mag = sr + si;
            if (mag > thr) begin
                esc = 1'b1;
            end else begin
                d = (sr - si) >>> 60;
                p = (er * ei) >>> 59;
                zr = clamp64(d + cr);
                zi = clamp64(p + ci);
                n++;
            end
        end
        res.iteration_count = 16'(n);
        res.escaped = esc;
        {res.red, res.green, res.blue} = esc ? hue_color((n % 90) % 90) : 24'h0;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (i_valid && !o_stall)
                pixels_due.push_back(escape_pixel(i_data, bail_cfg, maxit_cfg));
            if (!i_valid || !o_stall) begin
                if (gap_cnt != 0) begin
                    gap_cnt <= gap_cnt - 1;
                    i_valid <= 1'b0;
                end else if (points.size() != 0) begin
                    i_data <= points.pop_front();
                    i_valid <= 1'b1;
                    gap_cnt <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        mandel_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_data);
            end else begin
                want = pixels_due.pop_front();
                if (o_data.iteration_count !== want.iteration_count ||
                    o_data.escaped !== want.escaped || o_data.red !== want.red ||
                    o_data.green !== want.green || o_data.blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_data);
                end
            end
        end
        // A single long hold-off lets the block fill up and stall its input.
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            stall_cnt <= 600;
            i_stall <= 1'b1;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            i_stall <= 1'b1;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            i_stall <= 1'b0;
        end else begin
            stall_cnt <= pick_gap();
            i_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** mandelbrot_escape_time_pixel: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [mandel_pkg::CFG_ADDR_WIDTH-1:0] addr,
                             input logic [mandel_pkg::CFG_DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        if (addr == mandel_pkg::REG_BAIL_EXPONENT)
            bail_cfg = data[2:0];
        else
            maxit_cfg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input logic [2:0] bail, input logic [15:0] limit);
        write_reg(mandel_pkg::REG_BAIL_EXPONENT, {13'd0, bail});
        write_reg(mandel_pkg::REG_MAX_ITERATIONS, limit);
    endtask

    task automatic add_point(input logic [63:0] re, input logic [63:0] im);
        mandel_pkg::t_in_item c;
        c.c_real = re;
        c.c_imag = im;
        points.push_back(c);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (points.size() != 0 || i_valid || pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Coordinates have 60 fraction bits, so 1.0 is 2^60.
    localparam logic [63:0] ONE = 64'h1000_0000_0000_0000;

    task automatic add_random_point();
        logic signed [63:0] a;
        logic signed [63:0] b;
        int unsigned r;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 60)
            add_point((a >>> 2) - (ONE >>> 1), b >>> 2);
        else if (r < 85)
            add_point((a >>> 5) - (ONE - (ONE >>> 2)), (b >>> 5) + (ONE >>> 3));
        else
            add_point(a, b);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a bounded point at the full default limit, a slow escape whose
        // count wraps past the palette length, a faster escape and the corners of the range.
        add_point(64'd0, 64'd0);
        add_point(ONE / 4 + ONE / 10000, 64'd0);
        add_point(ONE / 4 + ONE / 100, 64'd0);
        add_point({1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}});
        add_point({1'b1, 63'd0}, {1'b1, 63'd0});
        add_point({1'b0, {63{1'b1}}}, {1'b1, 63'd0});
        drain();

        // A zero limit does no passes at all.
        set_limits(3'd2, 16'd0);
        add_point(64'd0, 64'd0);
        add_point(ONE * 3, ONE);
        drain();

        // Largest limit, only with points that leave quickly.
        set_limits(3'd1, 16'hffff);
        add_point(ONE * 2, ONE);
        add_point({1'b1, 63'd0}, 64'd0);
        add_point(ONE, ONE / 2);
        drain();

        // Bail exponents at both ends of their range, then 6; the largest lets z overflow and saturate.
        set_limits(3'd0, 16'd20);
        add_point(ONE / 2, ONE / 2);
        add_point(-(ONE / 2), 64'd0);
        drain();
        set_limits(3'd7, 16'd20);
        add_point({1'b1, 63'd0}, {1'b1, 63'd0});
        add_point(ONE * 7, -(ONE * 7));
        add_point(-(ONE * 2), 64'd0);
        drain();
        set_limits(3'd6, 16'd30);
        add_point(ONE * 5, ONE * 5);
        add_point(-(ONE * 3 / 4), ONE / 10);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph % 3 == 2);
            set_limits((ph % 4 == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 6)),
                       16'($urandom_range(1, 48)));
            if (ph == 4)
                hold_req = 1'b1;
            for (int k = 0; k < 56; k++)
                add_random_point();
            drain();
        end

        if (mismatches == 0)
            $display("** mandelbrot_escape_time_pixel: PASSED **");
        else
            $display("** mandelbrot_escape_time_pixel: FAILED **");
        $finish;
    end

endmodule

### files.f
design/mandel_pkg.sv
design/mandel_mul_cell.sv
design/mandel_mul_row.sv
design/mandelbrot_escape_time_pixel.sv
design/mandel_checker.sv
verif/tb.sv
